// File: design/tpv_pkg.sv
package tpv_pkg;

    localparam int DEF_MAX_PLY   = 64;
    localparam int DEF_MOVE_BITS = 32;

    // operation codes
    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_EMPTY_LINE = 3'd1;
    localparam logic [2:0] OP_ADD_MOVE   = 3'd2;
    localparam logic [2:0] OP_READ_MOVE  = 3'd3;
    localparam logic [2:0] OP_READ_LINE  = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  ply;
        logic [31:0] move_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] move_out;
        logic [5:0]  column;
        logic        last;
    } t_out_item;

endpackage

// File: design/triangular_pv_table_unit.sv
// Clear and empty line act at the accepting edge. Read move passes S_RDM_A and S_RDM_B
// (only S_RDM_B outside the table), then loads the output register. Read line passes
// S_LN_A, S_LN_B, S_LN_S and gives one word per free output cycle. Add passes S_ADD_A,
// S_ADD_B, then S_ADD_C and S_COPY if the deeper row is inside. One item at a time.
// Reset: synchronous, active low; move words and end indices read as zero at once through
// per-row valid flags, with no clearing pass.
module triangular_pv_table_unit
    import tpv_pkg::*;
#(
    parameter int MAX_PLY   = DEF_MAX_PLY,
    parameter int MOVE_BITS = DEF_MOVE_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_item o_out
);

    // column/row index width and width of an absolute end index (0..MAX_PLY)
    localparam int PLY_W = (MAX_PLY > 1) ? $clog2(MAX_PLY) : 1;
    localparam int END_W = $clog2(MAX_PLY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_A,    // write diagonal, read own row info
        S_ADD_B,    // capture own fill, read deeper row info
        S_ADD_C,    // capture deeper end and fill
        S_COPY,     // pipelined tail copy, one word per cycle
        S_RDM_A,    // read diagonal word
        S_RDM_B,    // present diagonal word
        S_LN_A,     // read row info
        S_LN_B,     // capture end, decide if empty
        S_LN_S      // stream line words
    } t_state;

    // ------------------------------------------------------------------
    // Storage
    // Move words live in one RAM. Each row also keeps a fill mark: columns
    // from the diagonal up to the fill were written since the last clear.
    // Anything at or beyond the fill, or in a row whose fill flag is down,
    // reads as zero. Since every write to a row starts at its diagonal and
    // is contiguous, this is exact, and clear only drops the fill flags.
    // ------------------------------------------------------------------
    logic [MOVE_BITS-1:0] r_mv_mem [MAX_PLY][MAX_PLY];
    logic [END_W-1:0]     r_le_mem [MAX_PLY];
    logic [END_W-1:0]     r_fill_mem [MAX_PLY];
    logic [MOVE_BITS-1:0] r_mv_q;
    logic [END_W-1:0]     r_le_q;
    logic [END_W-1:0]     r_fill_q;
    logic [MAX_PLY-1:0]   r_fvalid;   // fill mark valid, dropped by clear
    logic [MAX_PLY-1:0]   r_levalid;  // end index written since reset

    // sequencer registers
    t_state               r_state;
    logic [PLY_W-1:0]     r_row;
    logic [5:0]           r_ply;
    logic                 r_inside;
    logic [MOVE_BITS-1:0] r_move;
    logic [END_W-1:0]     r_fill_p;   // own fill before the add
    logic [END_W-1:0]     r_end;      // end of the line being copied/streamed
    logic [END_W-1:0]     r_fill_src; // fill of the source row
    logic                 r_src_ok;
    logic [END_W-1:0]     r_rcol;     // read column
    logic [PLY_W-1:0]     r_wcol;     // write column, one behind r_rcol
    logic                 r_wpend;
    logic                 r_wok;
    logic                 r_dv;       // r_mv_q holds the word at r_rcol
    logic                 r_out_valid;
    t_out_item            r_out;

    // combinational control
    logic                 in_acc;
    logic                 in_inside;
    logic [PLY_W-1:0]     in_row;
    logic [END_W-1:0]     row_d;
    logic                 d_past;
    logic [PLY_W-1:0]     d_idx;
    logic                 out_free;
    logic                 out_load;
    logic [END_W-1:0]     fill_p_eff;
    logic                 ln_emit;
    logic                 fin_add;
    logic [END_W-1:0]     rcol_inc;
    logic [END_W-1:0]     add_hi;

    logic [PLY_W-1:0]     info_raddr;
    logic [PLY_W-1:0]     info_waddr;
    logic                 le_we;
    logic [END_W-1:0]     le_wdata;
    logic                 fill_we;
    logic [END_W-1:0]     fill_wdata;

    logic [PLY_W-1:0]     mv_rrow;
    logic [PLY_W-1:0]     mv_rcol;
    logic                 mv_we;
    logic [PLY_W-1:0]     mv_wrow;
    logic [PLY_W-1:0]     mv_wcol;
    logic [MOVE_BITS-1:0] mv_wdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        in_acc     = i_in_valid && !o_in_stall;
        in_row     = i_in.ply[PLY_W-1:0];
        in_inside  = (7'(i_in.ply) < 7'(MAX_PLY));
        row_d      = END_W'(r_row) + END_W'(1);
        d_past     = (row_d == END_W'(MAX_PLY));
        d_idx      = row_d[PLY_W-1:0];
        out_free   = !r_out_valid || !i_out_stall;
        fill_p_eff = r_fvalid[r_row] ? r_fill_q : '0;
        rcol_inc   = r_rcol + END_W'(1);
        ln_emit    = (r_state == S_LN_S) && r_dv && out_free;
        out_load   = ((r_state == S_RDM_B) && out_free) || ln_emit;
        add_hi     = (r_end > row_d) ? r_end : row_d;

        // add finishes once the copy pipe has drained, or at once when
        // the deeper row lies past the table
        fin_add = ((r_state == S_ADD_B) && d_past) ||
                  ((r_state == S_COPY) && (r_rcol >= r_end) && !r_wpend);

        // row info port
        info_raddr = (r_state == S_ADD_B) ? d_idx : r_row;
        info_waddr = (r_state == S_IDLE) ? in_row : r_row;
        le_we      = fin_add ||
                     (in_acc && (i_in.op == OP_EMPTY_LINE) && in_inside);
        if (r_state == S_IDLE) begin
            le_wdata = END_W'(in_row);
        end else if (r_state == S_ADD_B) begin
            le_wdata = row_d;
        end else begin
            le_wdata = r_end;
        end
        fill_we = fin_add;
        if (r_state == S_ADD_B) begin
            fill_wdata = (fill_p_eff > row_d) ? fill_p_eff : row_d;
        end else begin
            fill_wdata = (r_fill_p > add_hi) ? r_fill_p : add_hi;
        end

        // move store read port
        mv_rrow = r_row;
        mv_rcol = r_row;
        case (r_state)
            S_COPY: begin
                mv_rrow = d_idx;
                mv_rcol = r_rcol[PLY_W-1:0];
            end
            S_LN_S: begin
                // look one ahead on a transfer so streaming keeps one word a cycle while the output is free
                mv_rcol = ln_emit ? rcol_inc[PLY_W-1:0] : r_rcol[PLY_W-1:0];
            end
            default: begin
            end
        endcase

        // move store write port
        mv_we    = 1'b0;
        mv_wrow  = r_row;
        mv_wcol  = r_row;
        mv_wdata = r_move;
        case (r_state)
            S_ADD_A: begin
                mv_we = 1'b1;
            end
            S_COPY: begin
                mv_we    = r_wpend;
                mv_wcol  = r_wcol;
                mv_wdata = r_wok ? r_mv_q : '0;
            end
            default: begin
            end
        endcase
    end

    // move store RAM, registered read
    always_ff @(posedge i_clk) begin
        if (mv_we) begin
            r_mv_mem[mv_wrow][mv_wcol] <= mv_wdata;
        end
        r_mv_q <= r_mv_mem[mv_rrow][mv_rcol];
    end

    // row info RAMs, registered read
    always_ff @(posedge i_clk) begin
        if (le_we) begin
            r_le_mem[info_waddr] <= le_wdata;
        end
        if (fill_we) begin
            r_fill_mem[info_waddr] <= fill_wdata;
        end
        r_le_q   <= r_le_mem[info_raddr];
        r_fill_q <= r_fill_mem[info_raddr];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fvalid    <= '0;
            r_levalid   <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_wpend     <= 1'b0;
        end else begin
            // output register drains on a transfer; emitting states refill it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (le_we) begin
                r_levalid[info_waddr] <= 1'b1;
            end
            if (fin_add) begin
                r_fvalid[r_row] <= 1'b1;
                r_state         <= S_IDLE;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_row    <= in_row;
                        r_ply    <= i_in.ply;
                        r_inside <= in_inside;
                        r_move   <= i_in.move_word[MOVE_BITS-1:0];
                        unique case (i_in.op)
                            OP_CLEAR: begin
                                r_fvalid <= '0;
                            end
                            OP_ADD_MOVE: begin
                                if (in_inside) begin
                                    r_state <= S_ADD_A;
                                end
                            end
                            OP_READ_MOVE: begin
                                // outside the table: go straight to a zero word
                                r_state <= in_inside ? S_RDM_A : S_RDM_B;
                            end
                            OP_READ_LINE: begin
                                if (in_inside) begin
                                    r_state <= S_LN_A;
                                end
                            end
                            default: begin
                                // empty line is a single write; other codes do nothing
                            end
                        endcase
                    end
                end
                S_ADD_A: begin
                    r_state <= S_ADD_B;
                end
                S_ADD_B: begin
                    r_fill_p <= fill_p_eff;
                    if (!d_past) begin
                        r_state <= S_ADD_C;
                    end
                end
                S_ADD_C: begin
                    r_end      <= r_levalid[d_idx] ? r_le_q : '0;
                    r_fill_src <= r_fill_q;
                    r_src_ok   <= r_fvalid[d_idx];
                    r_rcol     <= row_d;
                    r_wpend    <= 1'b0;
                    r_state    <= S_COPY;
                end
                S_COPY: begin
                    if (r_rcol < r_end) begin
                        r_rcol  <= rcol_inc;
                        r_wcol  <= r_rcol[PLY_W-1:0];
                        r_wok   <= r_src_ok && (r_rcol < r_fill_src);
                        r_wpend <= 1'b1;
                    end else begin
                        r_wpend <= 1'b0;
                    end
                end
                S_RDM_A: begin
                    r_state <= S_RDM_B;
                end
                S_RDM_B: begin
                    if (out_free) begin
                        r_out.move_out  <= (r_inside && r_fvalid[r_row] &&
                                            (END_W'(r_row) < r_fill_q)) ? 32'(r_mv_q) : '0;
                        r_out.column    <= r_ply;
                        r_out.last      <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_LN_A: begin
                    r_state <= S_LN_B;
                end
                S_LN_B: begin
                    r_end      <= r_levalid[r_row] ? r_le_q : '0;
                    r_fill_src <= r_fill_q;
                    r_src_ok   <= r_fvalid[r_row];
                    r_rcol     <= END_W'(r_row);
                    r_dv       <= 1'b0;
                    // empty line: no words at all
                    if (r_levalid[r_row] && (r_le_q > END_W'(r_row))) begin
                        r_state <= S_LN_S;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LN_S: begin
                    r_dv <= 1'b1;
                    if (ln_emit) begin
                        r_out.move_out <= (r_src_ok && (r_rcol < r_fill_src)) ?
                                          32'(r_mv_q) : '0;
                        r_out.column   <= 6'(r_rcol);
                        r_out.last     <= (rcol_inc == r_end);
                        r_rcol         <= rcol_inc;
                        if (rcol_inc == r_end) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // streaming never runs past the end of the line
    a_ln_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LN_S) |-> (r_rcol < r_end))
        else $error("line stream column past line end");

    // tail copy never overwrites the diagonal word just written
    a_copy_off_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && mv_we) |-> (r_wcol > r_row))
        else $error("tail copy hit the diagonal");

    // a read-move transfer always enters S_RDM_A or S_RDM_B
    a_rdm_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.op == OP_READ_MOVE)) |=>
            ((r_state == S_RDM_A) || (r_state == S_RDM_B)))
        else $error("read move did not enter its sequence");
`endif

endmodule
